// ----- src/sfs_pkg.sv -----
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the shooter feed sequencer: feeder modes,
// loop select codes, register indexes and the packed stream items.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // Feeder mode codes carried in an input request; codes above reverse are invalid
  typedef enum logic [2:0] {
    MODE_STOP    = 3'd0,
    MODE_SINGLE  = 3'd1,
    MODE_TRIPLE  = 3'd2,
    MODE_BURST   = 3'd3,
    MODE_REVERSE = 3'd4
  } feed_mode_e;

  // Feeder control loop selected for a tick
  typedef enum logic [2:0] {
    LOOP_HOLD    = 3'd0,
    LOOP_STOP    = 3'd1,
    LOOP_SINGLE  = 3'd2,
    LOOP_TRIPLE  = 3'd3,
    LOOP_BURST   = 3'd4,
    LOOP_REVERSE = 3'd5
  } loop_sel_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SHOT_ANGLE_STEP   = 3'd0,
    REG_SINGLE_DEAD_TICKS = 3'd1,
    REG_TRIPLE_DEAD_TICKS = 3'd2,
    REG_SLEW_PER_TICK     = 3'd3,
    REG_RATE_GAIN         = 3'd4,
    REG_FRICTION_SPEED_A  = 3'd5,
    REG_FRICTION_SPEED_B  = 3'd6,
    REG_FRICTION_SPEED_C  = 3'd7
  } cfg_reg_e;

  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 32;

  // Speed command stays between zero and rate * gain (10 x 16 bits)
  localparam int unsigned SpeedWidth = 26;

  // Friction speed for the default speed class
  localparam logic signed [31:0] DefaultFrictionSpeed = 32'sd0;

  // Reset values of the configuration registers
  localparam logic [23:0] ShotAngleStepRst   = 24'd9216;
  localparam logic [15:0] SingleDeadTicksRst = 16'd4000;
  localparam logic [15:0] TripleDeadTicksRst = 16'd8000;
  localparam logic [15:0] SlewPerTickRst     = 16'd256;
  localparam logic [15:0] RateGainRst        = 16'd1024;

  // Input request, first field in the lowest bits, padded to 88 bits
  typedef struct packed {
    logic [6:0]         pad;
    logic [1:0]         speed_class;
    logic               friction_enable;
    logic signed [31:0] feeder_angle;
    logic [9:0]         fire_rate;
    logic [2:0]         feed_mode;
    logic               shooter_off;
    logic [31:0]        time_now;
  } in_item_t;

  // Result, first field in the lowest bits, padded to 72 bits
  typedef struct packed {
    logic [1:0]         pad;
    logic               fault;
    logic signed [31:0] friction_ref;
    logic signed [31:0] feeder_ref;
    logic               ref_written;
    logic [2:0]         loop_select;
    logic               motors_enabled;
  } out_item_t;

  localparam int unsigned InWidth  = $bits(in_item_t);
  localparam int unsigned OutWidth = $bits(out_item_t);

endpackage

// ----- src/sfs_slew.sv -----
// ----------------------------------------------------------------------------
// sfs_slew
// Burst speed update: moves the speed command toward fire_rate * rate_gain,
// changing it by at most slew_per_tick * elapsed ticks.
// ----------------------------------------------------------------------------
module sfs_slew (
  input  logic [9:0]                    fire_rate_i,
  input  logic [15:0]                   rate_gain_i,
  input  logic [15:0]                   slew_per_tick_i,
  input  logic [30:0]                   dt_i,
  input  logic [sfs_pkg::SpeedWidth-1:0] speed_i,
  output logic [sfs_pkg::SpeedWidth-1:0] speed_o
);
  import sfs_pkg::*;

  logic [SpeedWidth-1:0]   target;
  logic [46:0]             slew_limit;
  logic [SpeedWidth:0]     delta_clip;
  logic signed [SpeedWidth+1:0] diff;
  logic signed [SpeedWidth+1:0] delta_s;
  logic [SpeedWidth:0]     step_up;
  logic [SpeedWidth:0]     step_down;

  // Target speed and largest allowed change
  assign target     = {16'd0, fire_rate_i} * {10'd0, rate_gain_i};
  assign slew_limit = slew_per_tick_i * dt_i;

  // Clip the change: anything beyond the speed range reaches the target anyway
  assign delta_clip = (slew_limit[46:SpeedWidth] != '0)
                    ? {1'b1, {SpeedWidth{1'b0}}}
                    : {1'b0, slew_limit[SpeedWidth-1:0]};

  assign diff    = $signed({2'b00, target}) - $signed({2'b00, speed_i});
  assign delta_s = $signed({1'b0, delta_clip});

  assign step_up   = {1'b0, speed_i} + {1'b0, slew_limit[SpeedWidth-1:0]};
  assign step_down = {1'b0, speed_i} - {1'b0, slew_limit[SpeedWidth-1:0]};

  // Step toward the target, or land on it when close enough
  always_comb begin
    priority if (diff > delta_s) begin
      speed_o = step_up[SpeedWidth-1:0];
    end else if (diff < -delta_s) begin
      speed_o = step_down[SpeedWidth-1:0];
    end else begin
      speed_o = target;
    end
  end

endmodule

// ----- src/shooter_feed_sequencer.sv -----
// ----------------------------------------------------------------------------
// shooter_feed_sequencer
// Projectile feeder and friction wheel sequencer, one control tick per request.
// ----------------------------------------------------------------------------
// Each input request is one control tick and yields one result. The tick is
// evaluated in the cycle it is accepted and its result is held in an output
// register, so a new request is taken every cycle while the output side
// keeps up; the only limit is the single result register, which stalls the
// input when a result waits and m_axis_tready is low. Single and triple modes
// latch an angle target and a cooldown on entry, burst mode slew-limits a
// speed command, and an invalid feeder mode halts the block with the fault
// flag set until reset. Configuration writes are taken at any time and are
// meant to happen while no request is in flight.
module shooter_feed_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sfs_pkg::CfgAddrWidth-1:0]  cfg_addr_i,
  input  logic [sfs_pkg::CfgDataWidth-1:0]  cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: time_now[31:0], shooter_off[32], feed_mode[35:33], fire_rate[45:36],
  //        feeder_angle[77:46], friction_enable[78], speed_class[80:79], zeros
  input  logic [sfs_pkg::InWidth-1:0]       s_axis_tdata,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: motors_enabled[0], loop_select[3:1], ref_written[4],
  //        feeder_ref[36:5], friction_ref[68:37], fault[69], zeros
  output logic [sfs_pkg::OutWidth-1:0]      m_axis_tdata
);
  import sfs_pkg::*;

  // Configuration registers
  logic [23:0]        shot_step_q;
  logic [15:0]        single_dead_q;
  logic [15:0]        triple_dead_q;
  logic [15:0]        slew_q;
  logic [15:0]        gain_q;
  logic signed [31:0] fric_a_q;
  logic signed [31:0] fric_b_q;
  logic signed [31:0] fric_c_q;

  // Tick state
  logic [2:0]             prev_mode_q, prev_mode_d;
  logic signed [31:0]     target_q, target_d;
  logic [31:0]            cd_start_q, cd_start_d;
  logic [15:0]            cd_len_q, cd_len_d;
  logic [SpeedWidth-1:0]  speed_q, speed_d;
  logic [31:0]            last_time_q, last_time_d;
  logic                   halted_q, halted_d;

  // Output register
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res;

  in_item_t              req;
  logic                  accept;
  logic                  bad_mode;
  logic                  cooling;
  logic [31:0]           since_cd;
  logic [SpeedWidth-1:0] speed_base;
  logic [31:0]           time_base;
  logic [SpeedWidth-1:0] burst_speed_in;
  logic [31:0]           burst_time_in;
  logic [31:0]           dt_raw;
  logic [30:0]           dt;
  logic [SpeedWidth-1:0] burst_speed;
  logic [25:0]           step3;
  logic [25:0]           addend;
  logic signed [33:0]    shot_sum;
  logic signed [31:0]    shot_sat;
  logic signed [31:0]    fric_lookup;

  assign req         = in_item_t'(s_axis_tdata);
  assign cfg_ready_o = 1'b1;

  // Take a request whenever the result register is free or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Configuration writes; unknown indexes cannot occur with a 3-bit index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shot_step_q   <= ShotAngleStepRst;
      single_dead_q <= SingleDeadTicksRst;
      triple_dead_q <= TripleDeadTicksRst;
      slew_q        <= SlewPerTickRst;
      gain_q        <= RateGainRst;
      fric_a_q      <= '0;
      fric_b_q      <= '0;
      fric_c_q      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_SHOT_ANGLE_STEP:   shot_step_q   <= cfg_data_i[23:0];
        REG_SINGLE_DEAD_TICKS: single_dead_q <= cfg_data_i[15:0];
        REG_TRIPLE_DEAD_TICKS: triple_dead_q <= cfg_data_i[15:0];
        REG_SLEW_PER_TICK:     slew_q        <= cfg_data_i[15:0];
        REG_RATE_GAIN:         gain_q        <= cfg_data_i[15:0];
        REG_FRICTION_SPEED_A:  fric_a_q      <= $signed(cfg_data_i);
        REG_FRICTION_SPEED_B:  fric_b_q      <= $signed(cfg_data_i);
        REG_FRICTION_SPEED_C:  fric_c_q      <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Shooter off clears the speed command before the mode logic
  assign speed_base = req.shooter_off ? '0 : speed_q;
  assign time_base  = req.shooter_off ? req.time_now : last_time_q;

  assign bad_mode = halted_q || (req.feed_mode > MODE_REVERSE);
  assign since_cd = req.time_now - cd_start_q;
  assign cooling  = since_cd < {16'd0, cd_len_q};

  // Burst entry restarts the command; a clock gone backward gives no time
  assign burst_speed_in = (prev_mode_q != MODE_BURST) ? '0 : speed_base;
  assign burst_time_in  = (prev_mode_q != MODE_BURST) ? req.time_now : time_base;
  assign dt_raw         = req.time_now - burst_time_in;
  assign dt             = dt_raw[31] ? '0 : dt_raw[30:0];

  sfs_slew u_slew (
    .fire_rate_i     (req.fire_rate),
    .rate_gain_i     (gain_q),
    .slew_per_tick_i (slew_q),
    .dt_i            (dt),
    .speed_i         (burst_speed_in),
    .speed_o         (burst_speed)
  );

  // Shot target: angle plus one or three steps, saturated at the positive end
  assign step3    = {1'b0, shot_step_q, 1'b0} + {2'b00, shot_step_q};
  assign addend   = (req.feed_mode == MODE_TRIPLE) ? step3 : {2'b00, shot_step_q};
  assign shot_sum = {{2{req.feeder_angle[31]}}, req.feeder_angle} + $signed({8'd0, addend});
  assign shot_sat = (!shot_sum[33] && (shot_sum[32:31] != 2'b00))
                  ? 32'sh7FFF_FFFF : shot_sum[31:0];

  // Friction wheel speed by class
  always_comb begin
    unique case (req.speed_class)
      2'd0:    fric_lookup = fric_a_q;
      2'd1:    fric_lookup = fric_b_q;
      2'd2:    fric_lookup = fric_c_q;
      default: fric_lookup = DefaultFrictionSpeed;
    endcase
  end

  // Evaluate one tick: next state and result
  always_comb begin
    prev_mode_d = prev_mode_q;
    target_d    = target_q;
    cd_start_d  = cd_start_q;
    cd_len_d    = cd_len_q;
    speed_d     = speed_q;
    last_time_d = last_time_q;
    halted_d    = halted_q;

    res                = '0;
    res.motors_enabled = !req.shooter_off;
    res.loop_select    = LOOP_STOP;
    res.ref_written    = 1'b1;
    res.feeder_ref     = '0;
    res.friction_ref   = req.friction_enable ? fric_lookup : 32'sd0;
    res.fault          = 1'b0;

    if (bad_mode) begin
      // Halt: freeze state, report the fault
      halted_d           = 1'b1;
      res.motors_enabled = 1'b0;
      res.loop_select    = LOOP_STOP;
      res.ref_written    = 1'b0;
      res.friction_ref   = '0;
      res.fault          = 1'b1;
    end else begin
      prev_mode_d = req.feed_mode;
      speed_d     = speed_base;
      last_time_d = time_base;
      priority if (cooling && (req.feed_mode == MODE_SINGLE ||
                               req.feed_mode == MODE_TRIPLE)) begin
        // Hold the latched target while cooling
        res.loop_select = LOOP_HOLD;
        res.feeder_ref  = target_q;
      end else if (req.feed_mode == MODE_STOP) begin
        res.loop_select = LOOP_STOP;
        speed_d         = '0;
        last_time_d     = req.time_now;
      end else if (req.feed_mode == MODE_SINGLE) begin
        res.loop_select = LOOP_SINGLE;
        res.feeder_ref  = target_q;
        if (prev_mode_q != MODE_SINGLE) begin
          target_d       = shot_sat;
          cd_start_d     = req.time_now;
          cd_len_d       = single_dead_q;
          res.feeder_ref = shot_sat;
        end
      end else if (req.feed_mode == MODE_TRIPLE) begin
        res.loop_select = LOOP_TRIPLE;
        res.feeder_ref  = target_q;
        speed_d         = '0;
        last_time_d     = req.time_now;
        if (prev_mode_q != MODE_TRIPLE) begin
          target_d       = shot_sat;
          cd_start_d     = req.time_now;
          cd_len_d       = triple_dead_q;
          res.feeder_ref = shot_sat;
        end
      end else if (req.feed_mode == MODE_BURST) begin
        res.loop_select = LOOP_BURST;
        speed_d         = burst_speed;
        last_time_d     = req.time_now;
        res.feeder_ref  = $signed({{(32-SpeedWidth){1'b0}}, burst_speed});
      end else begin
        // Reverse: no feeder reference
        res.loop_select = LOOP_REVERSE;
        res.ref_written = 1'b0;
        speed_d         = '0;
        last_time_d     = req.time_now;
      end
    end
  end

  // Tick state, advanced on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mode_q <= MODE_STOP;
      target_q    <= '0;
      cd_start_q  <= '0;
      cd_len_q    <= '0;
      speed_q     <= '0;
      last_time_q <= '0;
      halted_q    <= 1'b0;
    end else if (accept) begin
      prev_mode_q <= prev_mode_d;
      target_q    <= target_d;
      cd_start_q  <= cd_start_d;
      cd_len_q    <= cd_len_d;
      speed_q     <= speed_d;
      last_time_q <= last_time_d;
      halted_q    <= halted_d;
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

endmodule
